// ----- rtl/ssps_pkg.sv -----
// Package: shared types, constants and the direction table of the sound sorter.
package ssps_pkg;

  localparam int unsigned NumOut = 16;

  typedef enum logic [1:0] {
    CfgEnable = 2'd0,
    CfgVolume = 2'd1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    StIdle,
    StDivA,
    StDivB,
    StStore,
    StSortInit,
    StSortCmp,
    StSortIns,
    StEmit,
    StReject
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load_in;
    logic start_a;
    logic start_b;
    logic store;
    logic clr_count;
    logic sort_init;
    logic sort_cmp;
    logic sort_shift;
    logic sort_place;
    logic sort_next;
    logic emit_next;
    logic emit_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic div_done;
    logic full;
    logic last_in;
    logic empty;
    logic sort_done;
    logic keep_going;
    logic emit_last;
  } stat_t;

  localparam logic [15:0] DirTable [24] = '{
    16'h25a0, 16'h11f0, 16'h0b00, 16'h0730, 16'h0490, 16'h0290,
    16'h00d0, 16'h0000, 16'h0800, 16'h1700, 16'h2600, 16'h3500,
    16'h4400, 16'h5300, 16'h6200, 16'h7100, 16'h8f00, 16'h9e00,
    16'had00, 16'hbc00, 16'hcb00, 16'hda00, 16'he900, 16'hf800
  };

  // bearing from the ratio scan; x zero and y zero handled outside
  function automatic logic [15:0] bearing_scan(input logic [15:0] ratio, input logic xneg);
    logic [15:0] res;
    logic        hit;
    res = xneg ? DirTable[15] : DirTable[16];
    hit = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!hit && ratio >= DirTable[i]) begin
        hit = 1'b1;
        res = xneg ? DirTable[8 + i] : DirTable[23 - i];
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/ssps_if.sv -----
// Interfaces: valid/ready channels for requests, results and register writes.
interface ssps_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] priority_req;
  logic [7:0] volume;
  logic signed [7:0] rel_x;
  logic signed [7:0] rel_y;
  logic       last_entry;
  modport source (output valid, priority_req, volume, rel_x, rel_y, last_entry, input ready);
  modport sink   (input valid, priority_req, volume, rel_x, rel_y, last_entry, output ready);
endinterface

interface ssps_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  entry_index;
  logic [7:0]  attenuation;
  logic [15:0] bearing;
  logic        rejected;
  logic        last_result;
  modport source (output valid, entry_index, attenuation, bearing, rejected, last_result,
                  input ready);
  modport sink   (input valid, entry_index, attenuation, bearing, rejected, last_result,
                  output ready);
endinterface

interface ssps_cfg_if;
  logic       valid;
  logic       ready;
  logic [0:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/ssps_div.sv -----
// Restoring divider: one quotient bit per cycle.
module ssps_div #(
  parameter int unsigned NumW = 19,
  parameter int unsigned DenW = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] quo_q, quo_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  // shift one numerator bit into the remainder and try a subtract
  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DenW-1:0], quo_q[NumW-1]};
    if (start_i) begin
      quo_d  = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = trial - {1'b0, den_q};
        quo_d = {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quo_o  = quo_q;
endmodule

// ----- rtl/ssps_datapath.sv -----
// Datapath: request capture, dividers, entry stores, insertion sort and result register.
module ssps_datapath #(
  parameter int unsigned MaxEntries = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ssps_pkg::ctrl_t      ctrl_i,
  output ssps_pkg::stat_t      stat_o,
  input  logic [7:0]           priority_req_i,
  input  logic [7:0]           volume_i,
  input  logic signed [7:0]    rel_x_i,
  input  logic signed [7:0]    rel_y_i,
  input  logic                 last_entry_i,
  output logic [3:0]           entry_index_o,
  output logic [7:0]           attenuation_o,
  output logic [15:0]          bearing_o
);
  import ssps_pkg::*;

  localparam int unsigned IdxW = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned CntW = $clog2(MaxEntries + 1);

  // captured request
  logic [7:0]  pri_q, vol_q;
  logic [7:0]  ax_q, ay_q;
  logic        xneg_q, xzero_q, yzero_q, last_q;
  logic [7:0]  ax_d, ay_d;

  // stores
  logic [7:0]  pri_mem [MaxEntries];
  logic [7:0]  att_mem [MaxEntries];
  logic [15:0] brg_mem [MaxEntries];
  logic [IdxW-1:0] ord_mem [MaxEntries];
  logic [CntW-1:0] count_q;

  // sort state
  logic [CntW-1:0] i_q, j_q;
  logic [IdxW-1:0] cur_q, prev_q;
  logic [7:0]  pri_cur_q, att_cur_q, pri_prev_q, att_prev_q;
  logic        keep;

  // divider operands
  logic [15:0] sq_sum;
  logic [16:0] den_a;
  logic        done_a, done_b;
  logic [18:0] quo_a;
  logic [18:0] quo_b;
  logic [15:0] brg;

  assign ax_d = rel_x_i[7] ? 8'(-rel_x_i) : rel_x_i;
  assign ay_d = rel_y_i[7] ? 8'(-rel_y_i) : rel_y_i;

  // capture the request beat
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      pri_q   <= priority_req_i;
      vol_q   <= volume_i;
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      xneg_q  <= rel_x_i[7];
      xzero_q <= (rel_x_i == '0);
      yzero_q <= (rel_y_i == '0);
      last_q  <= last_entry_i;
    end
  end

  // squares go through one small multiplier each, registered in the divider
  assign sq_sum = 16'(ax_q * ax_q) + 16'(ay_q * ay_q);
  assign den_a  = {1'b0, sq_sum} + 17'd8;

  // both dividers take the same number of steps so they finish together
  ssps_div #(.NumW(19), .DenW(17)) u_div_att (
    .clk_i, .rst_ni,
    .start_i (ctrl_i.start_a),
    .num_i   ({3'b0, vol_q, 8'd0}),
    .den_i   (den_a),
    .done_o  (done_a),
    .quo_o   (quo_a)
  );

  // full |x|<<11 numerator; the ratio keeps the low 16 quotient bits
  ssps_div #(.NumW(19), .DenW(8)) u_div_brg (
    .clk_i, .rst_ni,
    .start_i (ctrl_i.start_b),
    .num_i   ({ax_q, 11'd0}),
    .den_i   (ay_q),
    .done_o  (done_b),
    .quo_o   (quo_b)
  );

  always_comb begin
    if (xzero_q)      brg = 16'h8000;
    else if (yzero_q) brg = xneg_q ? DirTable[8] : DirTable[23];
    else              brg = bearing_scan(quo_b[15:0], xneg_q);
  end

  // write the entry stores
  always_ff @(posedge clk_i) begin
    if (ctrl_i.store) begin
      pri_mem[count_q[IdxW-1:0]] <= pri_q;
      att_mem[count_q[IdxW-1:0]] <= quo_a[12:5];
      brg_mem[count_q[IdxW-1:0]] <= brg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (ctrl_i.clr_count) begin
      count_q <= '0;
    end else if (ctrl_i.store) begin
      count_q <= count_q + 1'b1;
    end
  end

  // insertion sort: i walks the entries, j walks back through the order
  always_ff @(posedge clk_i) begin
    if (ctrl_i.sort_init) begin
      i_q <= '0;
    end
    if (ctrl_i.sort_next) begin
      cur_q     <= i_q[IdxW-1:0];
      pri_cur_q <= pri_mem[i_q[IdxW-1:0]];
      att_cur_q <= att_mem[i_q[IdxW-1:0]];
      j_q       <= i_q;
      i_q       <= i_q + 1'b1;
    end
    if (ctrl_i.sort_cmp) begin
      prev_q     <= ord_mem[IdxW'(j_q - 1'b1)];
      pri_prev_q <= pri_mem[ord_mem[IdxW'(j_q - 1'b1)]];
      att_prev_q <= att_mem[ord_mem[IdxW'(j_q - 1'b1)]];
    end
    if (ctrl_i.sort_shift) begin
      ord_mem[j_q[IdxW-1:0]] <= prev_q;
      j_q <= j_q - 1'b1;
    end
    if (ctrl_i.sort_place) begin
      ord_mem[j_q[IdxW-1:0]] <= cur_q;
    end
    if (ctrl_i.emit_load) begin
      j_q <= '0;
    end
    if (ctrl_i.emit_next) begin
      entry_index_o <= 4'(ord_mem[j_q[IdxW-1:0]]);
      attenuation_o <= att_mem[ord_mem[j_q[IdxW-1:0]]];
      bearing_o     <= brg_mem[ord_mem[j_q[IdxW-1:0]]];
      j_q           <= j_q + 1'b1;
    end
  end

  always_comb begin
    keep = (pri_prev_q != pri_cur_q) ? (pri_prev_q > pri_cur_q)
                                     : (att_prev_q >= att_cur_q);
  end

  assign stat_o.div_done   = done_a && done_b;
  assign stat_o.full       = (count_q >= CntW'(MaxEntries));
  assign stat_o.last_in    = last_q;
  assign stat_o.empty      = (count_q == '0);
  assign stat_o.sort_done  = (i_q == count_q);
  assign stat_o.keep_going = (j_q != '0) && !keep;
  assign stat_o.emit_last  = (32'(j_q) + 1 >= 32'(count_q)) || (32'(j_q) + 1 >= NumOut);
endmodule

// ----- rtl/ssps_ctrl.sv -----
// Controller: sequences load, division, sort and emission of a batch.
module ssps_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssps_pkg::stat_t stat_i,
  input  logic            gate_ok_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_rej_o,
  output logic            out_last_o,
  output ssps_pkg::ctrl_t ctrl_o
);
  import ssps_pkg::*;

  state_e state_q, state_d;
  logic   ov_q, ov_d, rej_q, rej_d, lst_q, lst_d;
  logic   free;

  assign free = !ov_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ov_d    = ov_q && !out_ready_i;
    rej_d   = rej_q;
    lst_d   = lst_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = !ov_q;
        if (in_valid_i && !ov_q) begin
          ctrl_o.load_in = 1'b1;
          state_d = StDivA;
        end
      end
      StDivA: begin
        ctrl_o.start_a = 1'b1;
        ctrl_o.start_b = 1'b1;
        state_d = StDivB;
      end
      StDivB: begin
        if (stat_i.div_done) state_d = StStore;
      end
      StStore: begin
        ctrl_o.store = !stat_i.full;
        if (!stat_i.last_in) state_d = StIdle;
        else if (!gate_ok_i) state_d = StReject;
        else state_d = StSortInit;
      end
      StSortInit: begin
        ctrl_o.sort_init = 1'b1;
        state_d = StSortCmp;
      end
      StSortCmp: begin
        if (stat_i.sort_done) begin
          ctrl_o.emit_load = 1'b1;
          state_d = stat_i.empty ? StIdle : StEmit;
          if (stat_i.empty) ctrl_o.clr_count = 1'b1;
        end else begin
          ctrl_o.sort_next = 1'b1;
          state_d = StSortIns;
        end
      end
      StSortIns: begin
        // fetch predecessor then decide
        ctrl_o.sort_cmp = 1'b1;
        state_d = StSortIns;
        if (rej_q) begin
          rej_d = 1'b0;
          if (stat_i.keep_going) begin
            ctrl_o.sort_shift = 1'b1;
            ctrl_o.sort_cmp   = 1'b0;
            rej_d = 1'b0;
          end else begin
            ctrl_o.sort_place = 1'b1;
            ctrl_o.sort_cmp   = 1'b0;
            state_d = StSortCmp;
          end
        end else begin
          rej_d = 1'b1;
        end
      end
      StEmit: begin
        if (free) begin
          ctrl_o.emit_next = 1'b1;
          ov_d  = 1'b1;
          rej_d = 1'b0;
          lst_d = stat_i.emit_last;
          if (stat_i.emit_last) begin
            ctrl_o.clr_count = 1'b1;
            state_d = StIdle;
          end
        end
      end
      StReject: begin
        if (free) begin
          ctrl_o.clr_count = 1'b1;
          ov_d  = 1'b1;
          lst_d = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
      rej_q   <= 1'b0;
      lst_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      rej_q   <= (state_q == StReject && free) ? 1'b1 : rej_d;
      lst_q   <= lst_d;
    end
  end

  assign out_valid_o = ov_q;
  assign out_rej_o   = rej_q && ov_q && (state_q != StSortIns);
  assign out_last_o  = lst_q;
endmodule

// ----- rtl/spatial_sound_priority_sorter.sv -----
// Top level: sound request sorter with register port.
// Usage:
//   req_if carries one sound request per beat; last_entry closes a batch.
//   res_if returns the batch's results, highest priority then loudest
//   attenuation first, ties in load order; last_result marks the final beat.
//   cfg_if writes the enable bit (index 0) and master_volume (index 1); write
//   only while the block is idle.
// Sequence:
//   Each request is taken in StIdle, starts both 19-bit dividers side by
//   side in StDivA, waits in StDivB for their quotient bits and is stored
//   in StStore before the next one is taken. After the last request an
//   insertion sort runs, each comparison fetching a predecessor then
//   deciding, then one result per cycle while the receiver takes them.
//   A closed gate gives one rejected beat with zero fields.
// Reset: registers return to enabled, volume 7, empty batch.
// Stall: the result register holds while res_if.ready is low; the sequence
// waits behind it and requests are not taken until the batch is delivered.
module spatial_sound_priority_sorter #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssps_req_if.sink   req_if,
  ssps_res_if.source res_if,
  ssps_cfg_if.sink   cfg_if
);
  import ssps_pkg::*;

  ctrl_t      ctrl;
  stat_t      stat;
  logic       en_q;
  logic [7:0] vol_q;
  logic       rej;
  logic [3:0] idx;
  logic [7:0] att;
  logic [15:0] brg;

  // register writes
  assign cfg_if.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q  <= 1'b1;
      vol_q <= 8'd7;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_e'({1'b0, cfg_if.index}))
        CfgEnable: en_q  <= cfg_if.data[0];
        CfgVolume: vol_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  ssps_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .stat_i      (stat),
    .gate_ok_i   (en_q && (vol_q != '0)),
    .in_valid_i  (req_if.valid),
    .in_ready_o  (req_if.ready),
    .out_valid_o (res_if.valid),
    .out_ready_i (res_if.ready),
    .out_rej_o   (rej),
    .out_last_o  (res_if.last_result),
    .ctrl_o      (ctrl)
  );

  ssps_datapath #(.MaxEntries(MAX_ENTRIES)) u_dp (
    .clk_i, .rst_ni,
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .priority_req_i (req_if.priority_req),
    .volume_i       (req_if.volume),
    .rel_x_i        (req_if.rel_x),
    .rel_y_i        (req_if.rel_y),
    .last_entry_i   (req_if.last_entry),
    .entry_index_o  (idx),
    .attenuation_o  (att),
    .bearing_o      (brg)
  );

  // zero the fields of a rejected beat
  assign res_if.rejected    = rej;
  assign res_if.entry_index = rej ? '0 : idx;
  assign res_if.attenuation = rej ? '0 : att;
  assign res_if.bearing     = rej ? '0 : brg;
endmodule
